// File: sv/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppression core.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int MAX_BOXES_DEF = 64;
  localparam int COORD_W       = 16;
  localparam int SCORE_W       = 16;
  localparam int LABEL_W       = 7;
  localparam int CORNERS_W     = 4 * COORD_W;
  localparam int BOX_W         = CORNERS_W + SCORE_W + LABEL_W;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int AREA_W        = 2 * DIFF_W;
  localparam int KEPT_W        = CORNERS_W + AREA_W;
  localparam int MUL_A_W       = AREA_W + 2;
  localparam int MUL_B_W       = DIFF_W + 1;
  localparam int MUL_P_W       = MUL_A_W + MUL_B_W;
  localparam int THR_W         = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_START,
    ST_SCAN,
    ST_CRD,
    ST_CWAIT,
    ST_CAREA,
    ST_KRD,
    ST_KINT,
    ST_KUNI,
    ST_KTHR,
    ST_KCMP,
    ST_KEEP,
    ST_EMIT,
    ST_FINAL,
    ST_FEMIT
  } gbs_state_t;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } gbs_mul_op_t;

endpackage

// File: sv/gbs_ram.sv
// ----------------------------------------------------------------------------
// gbs_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module gbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/gbs_mul.sv
// ----------------------------------------------------------------------------
// gbs_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module gbs_mul import gbs_pkg::*; (
  input  logic                      clk,
  input  gbs_mul_op_t               op,
  output logic signed [MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op.a * op.b;
  end

endmodule

// File: sv/greedy_box_suppression_core.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression_core
// Greedy non-maximum suppression over one frame of candidate boxes.
// ----------------------------------------------------------------------------
// Boxes are loaded one word per cycle until a word with final_req closes the
// set. The core then repeatedly scans the box memory for the highest unused
// score (ties to the earlier box), reads the candidate and its area in the
// CRD, CWAIT and CAREA states, and tests it against each box kept so far,
// stopping at the first that suppresses it, in the KRD, KINT, KUNI, KTHR
// and KCMP states through the single shared multiplier. The single box
// memory read port and the shared multiplier set the cost of a set. The
// input is not ready until the last result of the set is taken.
// ----------------------------------------------------------------------------
module greedy_box_suppression_core import gbs_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [THR_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] left,
  input  logic signed [COORD_W-1:0] top,
  input  logic signed [COORD_W-1:0] right,
  input  logic signed [COORD_W-1:0] bottom,
  input  logic [SCORE_W-1:0]        score,
  input  logic [LABEL_W-1:0]        label,
  input  logic                      has_box,
  input  logic                      final_req,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_left,
  output logic signed [COORD_W-1:0] out_top,
  output logic signed [COORD_W-1:0] out_right,
  output logic signed [COORD_W-1:0] out_bottom,
  output logic [SCORE_W-1:0]        out_score,
  output logic [LABEL_W-1:0]        out_label,
  output logic                      none_kept,
  output logic                      overflowed,
  output logic                      out_last
);

  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);

  gbs_state_t state, state_next;

  logic [THR_W-1:0]     thr;
  logic [CNT_W-1:0]     box_count;
  logic                 ovf;
  logic [MAX_BOXES-1:0] done;
  logic [CNT_W-1:0]     kcnt;
  logic [IDX_W-1:0]     kaddr;
  logic [CNT_W-1:0]     scan_cnt;
  logic                 rd_v;
  logic [IDX_W-1:0]     rd_idx;
  logic                 best_v;
  logic [SCORE_W-1:0]   best_score;
  logic [IDX_W-1:0]     best_idx;
  logic [IDX_W-1:0]     cand;
  logic                 have_pend;

  logic [CORNERS_W-1:0]     c_corners;
  logic [SCORE_W-1:0]       c_score;
  logic [LABEL_W-1:0]       c_label;
  logic signed [AREA_W-1:0] c_area;
  logic [CORNERS_W-1:0]     p_corners;
  logic [SCORE_W-1:0]       p_score;
  logic [LABEL_W-1:0]       p_label;
  logic signed [AREA_W-1:0] inter_r;
  logic signed [MUL_A_W-1:0] union_r;

  logic                 in_acc;
  logic                 box_we;
  logic [IDX_W-1:0]     box_raddr;
  logic [BOX_W-1:0]     box_wdata;
  logic [BOX_W-1:0]     box_rdata;
  logic                 kept_we;
  logic [KEPT_W-1:0]    kept_wdata;
  logic [KEPT_W-1:0]    kept_rdata;
  logic                 issue;
  logic                 scan_end;
  logic                 suppress;
  logic                 last_kept;
  gbs_mul_op_t          mul_op;
  logic signed [MUL_P_W-1:0] prod;

  logic signed [COORD_W-1:0] cl, ct, cr, cb, kl, kt, kr, kb, rl, rt, rr, rb;
  logic signed [DIFF_W-1:0]  rw, rh, iw_raw, ih_raw, iw, ih;
  logic signed [COORD_W-1:0] min_r, max_l, min_b, max_t;
  logic signed [AREA_W-1:0]  k_area;
  logic signed [MUL_P_W-1:0] inter_sh;

  gbs_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
    .clk   (clk),
    .we    (box_we),
    .waddr (box_count[IDX_W-1:0]),
    .wdata (box_wdata),
    .raddr (box_raddr),
    .rdata (box_rdata)
  );

  gbs_ram #(.WIDTH(KEPT_W), .DEPTH(MAX_BOXES)) u_kept_ram (
    .clk   (clk),
    .we    (kept_we),
    .waddr (kcnt[IDX_W-1:0]),
    .wdata (kept_wdata),
    .raddr (kaddr),
    .rdata (kept_rdata)
  );

  gbs_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  // geometry
  assign cl = c_corners[15:0];
  assign ct = c_corners[31:16];
  assign cr = c_corners[47:32];
  assign cb = c_corners[63:48];
  assign kl = kept_rdata[15:0];
  assign kt = kept_rdata[31:16];
  assign kr = kept_rdata[47:32];
  assign kb = kept_rdata[63:48];
  assign k_area = kept_rdata[KEPT_W-1:CORNERS_W];
  assign rl = box_rdata[15:0];
  assign rt = box_rdata[31:16];
  assign rr = box_rdata[47:32];
  assign rb = box_rdata[63:48];
  assign rw = DIFF_W'(rr) - DIFF_W'(rl);
  assign rh = DIFF_W'(rb) - DIFF_W'(rt);
  assign min_r = (cr < kr) ? cr : kr;
  assign max_l = (cl > kl) ? cl : kl;
  assign min_b = (cb < kb) ? cb : kb;
  assign max_t = (ct > kt) ? ct : kt;
  assign iw_raw = DIFF_W'(min_r) - DIFF_W'(max_l);
  assign ih_raw = DIFF_W'(min_b) - DIFF_W'(max_t);
  assign iw = iw_raw[DIFF_W-1] ? '0 : iw_raw;
  assign ih = ih_raw[DIFF_W-1] ? '0 : ih_raw;
  assign inter_sh = {{(MUL_P_W-AREA_W-16){inter_r[AREA_W-1]}}, inter_r, 16'b0};
  assign suppress = (union_r > 0) && (inter_sh >= prod);
  assign last_kept = (CNT_W'(kaddr) + CNT_W'(1)) == kcnt;

  assign in_acc    = in_valid && in_ready;
  assign box_wdata = {label, score, bottom, right, top, left};
  assign box_we    = in_acc && has_box && (box_count < CNT_MAX);
  assign kept_wdata = {c_area, c_corners};
  assign issue     = (state == ST_SCAN) && (scan_cnt < box_count);
  assign scan_end  = !issue && !rd_v;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:       if (in_acc && final_req) state_next = ST_SCAN_START;
      ST_SCAN_START: state_next = ST_SCAN;
      ST_SCAN:       if (scan_end) state_next = best_v ? ST_CRD : ST_FINAL;
      ST_CRD:        state_next = ST_CWAIT;
      ST_CWAIT:      state_next = ST_CAREA;
      ST_CAREA:      state_next = (kcnt == '0) ? ST_KEEP : ST_KRD;
      ST_KRD:        state_next = ST_KINT;
      ST_KINT:       state_next = ST_KUNI;
      ST_KUNI:       state_next = ST_KTHR;
      ST_KTHR:       state_next = ST_KCMP;
      ST_KCMP: begin
        if (suppress) state_next = ST_SCAN_START;
        else if (last_kept) state_next = ST_KEEP;
        else state_next = ST_KRD;
      end
      ST_KEEP:       state_next = have_pend ? ST_EMIT : ST_SCAN_START;
      ST_EMIT:       if (out_ready) state_next = ST_SCAN_START;
      ST_FINAL:      state_next = ST_FEMIT;
      ST_FEMIT:      if (out_ready) state_next = ST_LOAD;
      default:       state_next = ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    kept_we   = 1'b0;
    box_raddr = cand;
    mul_op.a  = '0;
    mul_op.b  = '0;
    case (state)
      ST_LOAD:  in_ready = 1'b1;
      ST_SCAN:  box_raddr = scan_cnt[IDX_W-1:0];
      ST_CWAIT: begin
        mul_op.a = MUL_A_W'(rw);
        mul_op.b = MUL_B_W'(rh);
      end
      ST_KINT: begin
        mul_op.a = MUL_A_W'(iw);
        mul_op.b = MUL_B_W'(ih);
      end
      ST_KTHR: begin
        mul_op.a = union_r;
        mul_op.b = $signed({2'b00, thr});
      end
      ST_KEEP:  kept_we = 1'b1;
      ST_EMIT:  out_valid = 1'b1;
      ST_FEMIT: out_valid = 1'b1;
      default:  in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      thr       <= THR_RESET;
      box_count <= '0;
      ovf       <= 1'b0;
      done      <= '0;
      kcnt      <= '0;
      kaddr     <= '0;
      scan_cnt  <= '0;
      rd_v      <= 1'b0;
      best_v    <= 1'b0;
      have_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        thr <= cfg_wdata;
      end
      case (state)
        ST_LOAD: begin
          if (in_acc && has_box) begin
            if (box_count < CNT_MAX) box_count <= box_count + CNT_W'(1);
            else ovf <= 1'b1;
          end
        end
        ST_SCAN_START: begin
          scan_cnt <= '0;
          rd_v     <= 1'b0;
          best_v   <= 1'b0;
        end
        ST_SCAN: begin
          rd_v     <= issue;
          rd_idx   <= scan_cnt[IDX_W-1:0];
          scan_cnt <= scan_cnt + CNT_W'(issue);
          if (rd_v && !done[rd_idx] &&
              (!best_v || box_rdata[CORNERS_W +: SCORE_W] > best_score)) begin
            best_v     <= 1'b1;
            best_score <= box_rdata[CORNERS_W +: SCORE_W];
            best_idx   <= rd_idx;
          end
          if (scan_end && best_v) begin
            cand           <= best_idx;
            done[best_idx] <= 1'b1;
          end
        end
        ST_CWAIT: begin
          c_corners <= box_rdata[CORNERS_W-1:0];
          c_score   <= box_rdata[CORNERS_W +: SCORE_W];
          c_label   <= box_rdata[BOX_W-1 -: LABEL_W];
        end
        ST_CAREA: begin
          c_area <= prod[AREA_W-1:0];
          kaddr  <= '0;
        end
        ST_KUNI: begin
          inter_r <= prod[AREA_W-1:0];
          union_r <= MUL_A_W'(c_area) + MUL_A_W'(k_area) - MUL_A_W'(prod[AREA_W-1:0]);
        end
        ST_KCMP: begin
          if (!suppress && !last_kept) kaddr <= kaddr + IDX_W'(1);
        end
        ST_KEEP: begin
          kcnt      <= kcnt + CNT_W'(1);
          have_pend <= 1'b1;
          p_corners <= c_corners;
          p_score   <= c_score;
          p_label   <= c_label;
          if (have_pend) begin
            {out_bottom, out_right, out_top, out_left} <= p_corners;
            out_score  <= p_score;
            out_label  <= p_label;
            none_kept  <= 1'b0;
            overflowed <= ovf;
            out_last   <= 1'b0;
          end
        end
        ST_FINAL: begin
          if (have_pend) begin
            {out_bottom, out_right, out_top, out_left} <= p_corners;
            out_score <= p_score;
            out_label <= p_label;
          end else begin
            {out_bottom, out_right, out_top, out_left} <= '0;
            out_score <= '0;
            out_label <= '0;
          end
          none_kept  <= !have_pend;
          overflowed <= ovf;
          out_last   <= 1'b1;
        end
        ST_FEMIT: begin
          if (out_ready) begin
            box_count <= '0;
            ovf       <= 1'b0;
            done      <= '0;
            kcnt      <= '0;
            have_pend <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: tb/greedy_box_suppression_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_suppression_core_tb
// Sends frames of candidate boxes to the suppression core and checks every
// kept-box word against a score-ordered greedy overlap predictor kept here.
// ----------------------------------------------------------------------------
module greedy_box_suppression_core_tb import gbs_pkg::*; ();

  typedef struct packed {
    logic signed [15:0] l, t, r, b;
    logic [15:0] sc;
    logic [6:0] lb;
  } box_t;

  typedef struct packed {
    logic signed [15:0] l, t, r, b;
    logic [15:0] sc;
    logic [6:0] lb;
    logic nk, ov, last;
  } kept_word_t;

  localparam int BOX_BITS = $bits(box_t);

  logic clk = 0, rst = 1;
  logic cfg_wen = 0;
  logic [THR_W-1:0] cfg_wdata = '0;
  logic in_valid = 0, in_ready;
  logic signed [15:0] left = 0, top = 0, right = 0, bottom = 0;
  logic [15:0] score = 0;
  logic [6:0] label = 0;
  logic has_box = 0, final_req = 0;
  logic out_valid, out_ready = 0;
  logic signed [15:0] out_left, out_top, out_right, out_bottom;
  logic [15:0] out_score;
  logic [6:0] out_label;
  logic none_kept, overflowed, out_last;

  greedy_box_suppression_core u_dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .left(left), .top(top),
    .right(right), .bottom(bottom), .score(score), .label(label),
    .has_box(has_box), .final_req(final_req), .out_valid(out_valid),
    .out_ready(out_ready), .out_left(out_left), .out_top(out_top),
    .out_right(out_right), .out_bottom(out_bottom), .out_score(out_score),
    .out_label(out_label), .none_kept(none_kept), .overflowed(overflowed),
    .out_last(out_last)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #400ms;
    $display("greedy_box_suppression_core_tb failed");
    $finish;
  end

  // predictor state
  box_t frame_boxes[$];
  bit frame_overflow;
  logic [15:0] thr_q = THR_RESET;
  kept_word_t kept_q[$];
  int errors = 0, items_sent = 0, words_seen = 0, frames_closed = 0;
  bit no_idle = 0;

  function automatic bit overlap_suppresses(box_t a, box_t c);
    longint iw, ih, inter, uni;
    iw = ((a.r < c.r) ? a.r : c.r) - ((a.l > c.l) ? a.l : c.l);
    ih = ((a.b < c.b) ? a.b : c.b) - ((a.t > c.t) ? a.t : c.t);
    if (iw < 0) iw = 0;
    if (ih < 0) ih = 0;
    inter = iw * ih;
    uni = (longint'(a.r) - a.l) * (longint'(a.b) - a.t)
        + (longint'(c.r) - c.l) * (longint'(c.b) - c.t) - inter;
    if (uni <= 0) return 0;
    return inter * 65536 >= longint'(thr_q) * uni;
  endfunction

  task automatic predict_frame();
    int order[$];
    box_t kept[$];
    kept_word_t w;
    bit keep;
    int k;
    frames_closed++;
    if (frame_boxes.size() == 0) begin
      w = '0;
      w.nk = 1; w.ov = frame_overflow; w.last = 1;
      kept_q = {kept_q, w};
    end else begin
      for (int i = 0; i < frame_boxes.size(); i++) begin
        k = order.size();
        while (k > 0 && frame_boxes[order[k-1]].sc < frame_boxes[i].sc) k--;
        order.insert(k, i);
      end
      foreach (order[i]) begin
        keep = 1;
        foreach (kept[j]) if (overlap_suppresses(kept[j], frame_boxes[order[i]])) keep = 0;
        if (keep) begin
          kept = {kept, frame_boxes[order[i]]};
          w = '0;
          {w.l, w.t, w.r, w.b, w.sc, w.lb} = frame_boxes[order[i]];
          w.ov = frame_overflow;
          kept_q = {kept_q, w};
        end
      end
      kept_q[kept_q.size()-1].last = 1;
    end
    frame_boxes.delete();
    frame_overflow = 0;
  endtask

  task automatic send_word(box_t bx, bit hb, bit fin);
    if (!no_idle && $urandom_range(99) < 18) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 18);
    end
    in_valid <= 1;
    {left, top, right, bottom, score, label} <= bx;
    has_box <= hb;
    final_req <= fin;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (hb) begin
      if (frame_boxes.size() < 64) frame_boxes = {frame_boxes, bx};
      else frame_overflow = 1;
    end
    if (fin) predict_frame();
  endtask

  // checker and output stall
  always @(posedge clk) begin
    if (!rst) out_ready <= no_idle || ($urandom_range(99) >= 18);
    if (!rst && out_valid && out_ready) begin
      kept_word_t got, exp_w;
      got = {out_left, out_top, out_right, out_bottom, out_score, out_label,
             none_kept, overflowed, out_last};
      words_seen++;
      if (kept_q.size() == 0) begin
        $display("%t unexpected word %h", $time, got);
        errors++;
      end else begin
        exp_w = kept_q.pop_front();
        if (got !== exp_w) begin
          $display("%t mismatch expected %h actual %h", $time, exp_w, got);
          errors++;
        end
      end
    end
  end

  function automatic box_t rand_box(int span);
    box_t bx;
    int x, y;
    x = $urandom_range(2 * span) - span;
    y = $urandom_range(2 * span) - span;
    bx.l = 16'(x); bx.t = 16'(y);
    bx.r = 16'(x + $urandom_range(span));
    bx.b = 16'(y + $urandom_range(span));
    bx.sc = ($urandom_range(3) == 0) ? 16'($urandom_range(3) * 1000) : 16'($urandom);
    bx.lb = 7'($urandom);
    if ($urandom_range(19) == 0) bx = BOX_BITS'({$urandom, $urandom, $urandom});
    return bx;
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    cfg_wen <= 1; cfg_wdata <= v; thr_q = v;
    @(posedge clk);
    cfg_wen <= 0;
  endtask

  task automatic test_directed();
    box_t bx;
    send_word('0, 0, 1);
    bx = {16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'hffff, 7'h7f};
    send_word(bx, 1, 0);
    send_word({16'sd0, 16'sd0, 16'sd160, 16'sd160, 16'hffff, 7'd1}, 1, 0);
    send_word({16'sd8, 16'sd8, 16'sd168, 16'sd168, 16'h8000, 7'd2}, 1, 0);
    send_word({16'sd300, 16'sd300, 16'sd100, 16'sd100, 16'h0000, 7'd3}, 1, 0);
    send_word('0, 0, 0);
    send_word({16'sd5, 16'sd5, 16'sd5, 16'sd50, 16'h1234, 7'd0}, 1, 1);
    send_word({16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'h0001, 7'd4}, 1, 1);
    drain();
    write_threshold(16'd0);
    send_word({16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'h4000, 7'd5}, 1, 0);
    send_word({16'sd100, 16'sd100, 16'sd116, 16'sd116, 16'h4000, 7'd6}, 1, 0);
    send_word({16'sd200, 16'sd200, 16'sd216, 16'sd216, 16'h3000, 7'd7}, 1, 1);
    drain();
  endtask

  task automatic test_overflow();
    write_threshold(16'hffff);
    for (int i = 0; i < 67; i++) send_word(rand_box(200), 1, 0);
    send_word('0, 0, 1);
    for (int i = 0; i < 66; i++) send_word(rand_box(200), 1, 0);
    send_word('0, 0, 1);
    drain();
  endtask

  task automatic test_random(int count);
    int n;
    int phase;
    phase = 0;
    while (count > 0) begin
      phase++;
      if (phase % 6 == 0) begin
        drain();
        write_threshold((phase % 12 == 0) ? 16'($urandom) : 16'($urandom_range(16000, 50000)));
      end
      no_idle = (phase >= 10 && phase < 14);
      n = $urandom_range(12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) send_word(rand_box(400), 0, 0);
        else send_word(rand_box((i % 3 == 0) ? 2000 : 120), 1, 0);
      end
      if ($urandom_range(1)) send_word(rand_box(120), 1, 1);
      else send_word(rand_box(120), 0, 1);
      count -= n + 1;
    end
    no_idle = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_overflow();
    write_threshold(THR_RESET);
    test_random(175);
    drain();
    write_threshold(16'd29491);
    drain();
    $display("sent %0d words in %0d frames, checked %0d kept-box words",
             items_sent, frames_closed, words_seen);
    $display("thresholds covered zero, full scale, reset and random values");
    if (errors == 0 && kept_q.size() == 0)
      $display("greedy_box_suppression_core_tb passed");
    else
      $display("greedy_box_suppression_core_tb failed");
    $finish;
  end
endmodule
